/* src/tone_sequence_player_assert.svh */
// assertion macros for the tone sequence player
// depends on nothing; included inside the module body of the files that assert
`ifndef TONE_SEQUENCE_PLAYER_ASSERT_SVH
`define TONE_SEQUENCE_PLAYER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tone_sequence_player: assertion failed");

// next-cycle implication, checked outside reset
`define TSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tone_sequence_player: assertion failed");

`endif

/* src/tsp_pkg.sv */
// types, codes and sound rom tables for the tone sequence player
// depends on nothing
package tsp_pkg;

    localparam int NUM_SOUNDS = 16;
    localparam int MAX_STEPS  = 6;
    localparam int ID_W       = 4;
    localparam int IDX_W      = 3;
    localparam int MS_W       = 9;
    localparam int HZ_W       = 11;
    localparam int MODE_W     = 2;

    localparam logic [MS_W-1:0] ELAPSED_MAX = 9'd511;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [MODE_W-1:0] MODE_MUTE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALARMS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MINIMAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ALL     = 2'd3;

    localparam logic [ID_W-1:0] ALARM_ID_MIN   = 4'd10;
    localparam logic [ID_W-1:0] MINIMAL_ID_MIN = 4'd6;

    typedef struct packed {
        logic             active;
        logic             enabled;
        logic [ID_W-1:0]  sound;
        logic [IDX_W-1:0] idx;
        logic [MS_W-1:0]  elapsed;
    } t_state;

    localparam t_state STATE_RESET = '{
        active: 1'b0, enabled: 1'b1, sound: '0, idx: '0, elapsed: '0
    };

    localparam logic [IDX_W-1:0] SOUND_LEN [NUM_SOUNDS] = '{
        3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd3,
        3'd2, 3'd5, 3'd3, 3'd5, 3'd3, 3'd2, 3'd2, 3'd1
    };

    localparam logic [HZ_W-1:0] STEP_HZ [NUM_SOUNDS][MAX_STEPS] = '{
        '{11'd760,  11'd0,    11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd560,  11'd0,    11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd780,  11'd1290, 11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd1290, 11'd780,  11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd1000, 11'd760,  11'd800,  11'd0,   11'd0,    11'd0},
        '{11'd1000, 11'd840,  11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd560,  11'd0,    11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd1033, 11'd0,    11'd1033, 11'd0,   11'd0,    11'd0},
        '{11'd450,  11'd670,  11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd310,  11'd0,    11'd310,  11'd0,   11'd310,  11'd0},
        '{11'd80,   11'd0,    11'd80,   11'd0,   11'd0,    11'd0},
        '{11'd840,  11'd770,  11'd0,    11'd840, 11'd1000, 11'd0},
        '{11'd445,  11'd660,  11'd890,  11'd0,   11'd0,    11'd0},
        '{11'd660,  11'd890,  11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd445,  11'd660,  11'd0,    11'd0,   11'd0,    11'd0},
        '{11'd890,  11'd0,    11'd0,    11'd0,   11'd0,    11'd0}
    };

    localparam logic [MS_W-1:0] STEP_MS [NUM_SOUNDS][MAX_STEPS] = '{
        '{9'd180, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd180, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd120, 9'd80,  9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd120, 9'd80,  9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd300, 9'd200, 9'd300, 9'd0,   9'd0,   9'd0},
        '{9'd200, 9'd300, 9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd160, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd150, 9'd150, 9'd150, 9'd0,   9'd0,   9'd0},
        '{9'd200, 9'd50,  9'd0,   9'd0,   9'd0,   9'd0},
        '{9'd200, 9'd200, 9'd200, 9'd200, 9'd200, 9'd0},
        '{9'd200, 9'd200, 9'd350, 9'd0,   9'd0,   9'd0},
        '{9'd200, 9'd100, 9'd300, 9'd100, 9'd200, 9'd0},
        '{9'd500, 9'd400, 9'd300, 9'd0,   9'd0,   9'd0},
        '{9'd500, 9'd400, 9'd300, 9'd0,   9'd0,   9'd0},
        '{9'd500, 9'd400, 9'd300, 9'd0,   9'd0,   9'd0},
        '{9'd200, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0}
    };

    function automatic logic [HZ_W-1:0] step_hz_of(input logic [ID_W-1:0] snd,
                                                   input logic [IDX_W-1:0] idx);
        logic [HZ_W-1:0] hz;
        hz = '0;
        if (idx < IDX_W'(MAX_STEPS)) begin
            hz = STEP_HZ[snd][idx];
        end
        return hz;
    endfunction

    function automatic logic [MS_W-1:0] step_ms_of(input logic [ID_W-1:0] snd,
                                                   input logic [IDX_W-1:0] idx);
        logic [MS_W-1:0] ms;
        ms = '0;
        if (idx < IDX_W'(MAX_STEPS)) begin
            ms = STEP_MS[snd][idx];
        end
        return ms;
    endfunction

    function automatic logic mode_allows(input logic [MODE_W-1:0] mode,
                                         input logic [ID_W-1:0] id);
        logic ok;
        unique case (mode)
            MODE_MUTE:    ok = 1'b0;
            MODE_ALARMS:  ok = (id > ALARM_ID_MIN);
            MODE_MINIMAL: ok = (id > MINIMAL_ID_MIN);
            MODE_ALL:     ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

/* src/tone_sequence_player.sv */
// tone sequence player top level: step logic, state memory and output buffer
// depends on tsp_pkg and tone_sequence_player_assert.svh
//
// Takes one transaction per clock unless input stall is high: a start command
// picks one of 16 rom sounds and a tick command advances the playing sound by
// one millisecond. Every input transaction produces exactly one output
// transaction carrying the tone in Hz (0 for silence) and a busy flag. The
// player state lives in a one-entry synchronous memory with a registered read;
// the value written back by one transaction is forwarded to the next, so there
// is no bubble between commands. A two-entry output buffer (output register
// plus skid entry) lets the input keep flowing while a result waits; input
// stall rises only when both entries are full. The play mode register is
// sampled when a sound starts.
module tone_sequence_player (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic [tsp_pkg::ID_W-1:0]   i_sound_id,
    input  logic                       i_cfg_we,
    input  logic [tsp_pkg::MODE_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [tsp_pkg::HZ_W-1:0]   o_tone_hz,
    output logic                       o_busy_res
);
    import tsp_pkg::*;

    logic [MODE_W-1:0] r_play_mode;

    t_state            r_state_mem [1];
    t_state            r_rd_data;
    logic              r_mem_valid;
    logic              r_fwd_valid;
    t_state            r_fwd_data;

    logic              r_out_valid;
    logic [HZ_W-1:0]   r_out_hz;
    logic              r_out_busy;
    logic              r_skid_valid;
    logic [HZ_W-1:0]   r_skid_hz;
    logic              r_skid_busy;

    t_state            cur;
    t_state            n_state;
    logic [IDX_W-1:0]  len;
    logic [MS_W-1:0]   el_inc;
    logic              n_busy;
    logic [HZ_W-1:0]   n_hz;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = i_in_valid && !r_skid_valid;
    assign out_acc = r_out_valid && !i_out_stall;

    // current state with write-back forwarding
    always_comb begin
        if (r_fwd_valid) begin
            cur = r_fwd_data;
        end else if (r_mem_valid) begin
            cur = r_rd_data;
        end else begin
            cur = STATE_RESET;
        end
    end

    always_comb begin
        n_state = cur;
        len     = SOUND_LEN[cur.sound];
        el_inc  = (cur.elapsed == ELAPSED_MAX) ? cur.elapsed : cur.elapsed + 1'b1;
        if (i_cmd == CMD_START) begin
            n_state.sound   = i_sound_id;
            n_state.idx     = '0;
            n_state.elapsed = '0;
            n_state.enabled = mode_allows(r_play_mode, i_sound_id);
            n_state.active  = (SOUND_LEN[i_sound_id] != '0);
        end else if (cur.active && cur.enabled) begin
            n_state.elapsed = el_inc;
            if (cur.idx < len && el_inc >= step_ms_of(cur.sound, cur.idx)) begin
                n_state.idx     = cur.idx + 1'b1;
                n_state.elapsed = '0;
            end
            if (n_state.idx >= len) begin
                n_state.active = 1'b0;
            end
        end
        n_busy = n_state.active && n_state.enabled;
        n_hz   = '0;
        if (n_busy && n_state.idx < SOUND_LEN[n_state.sound]) begin
            n_hz = step_hz_of(n_state.sound, n_state.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_mode <= MODE_ALL;
        end else if (i_cfg_we) begin
            r_play_mode <= i_cfg_data;
        end
    end

    // state memory, read before write
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_state_mem[0];
        if (in_acc) begin
            r_state_mem[0] <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= in_acc;
            if (in_acc) begin
                r_mem_valid <= 1'b1;
            end
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_acc) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (in_acc) begin
                if (!r_out_valid || out_acc) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_acc) begin
                r_out_hz   <= r_skid_hz;
                r_out_busy <= r_skid_busy;
            end
        end else if (in_acc) begin
            if (!r_out_valid || out_acc) begin
                r_out_hz   <= n_hz;
                r_out_busy <= n_busy;
            end else begin
                r_skid_hz   <= n_hz;
                r_skid_busy <= n_busy;
            end
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_tone_hz   = r_out_hz;
    assign o_busy_res  = r_out_busy;

    `include "tone_sequence_player_assert.svh"

    `TSP_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `TSP_ASSERT_IMPLY(a_silent_when_idle, i_clk, i_rst_n, r_out_valid && !r_out_busy,
                      r_out_hz == '0)
    `TSP_ASSERT_IMPLY(a_idx_in_range, i_clk, i_rst_n, 1'b1,
                      cur.idx <= SOUND_LEN[cur.sound] || !r_mem_valid)
    `TSP_ASSERT_NEXT(a_fwd_after_accept, i_clk, i_rst_n, in_acc,
                     r_fwd_valid && r_mem_valid && r_out_valid)

endmodule
